[src/ptp_pkg.sv]
// Shared types, codes and constants of the periodic timer pool.
package ptp_pkg;

    localparam int NUM_TIMERS_DEF = 32;
    localparam int MAX_POOL       = 32;

    localparam int OP_W     = 3;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 2;
    localparam int TIME_W   = 32;
    localparam int MODE_W   = 2;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_CREATE  = 3'd1;
    localparam logic [OP_W-1:0] OP_START   = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd3;
    localparam logic [OP_W-1:0] OP_DESTROY = 3'd4;

    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_STATE = 2'd2;

    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // one slot's timing word
    typedef struct packed {
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] since_start;
    } timer_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load;         // latch request fields, set slot pointer
        logic rd;           // read word at slot pointer
        logic rd_ahead;     // read word at slot pointer + 1
        logic idx_inc;      // advance slot pointer
        logic tick_step;    // apply one tick to the current slot
        logic flush;        // send held expiry report as the final one
        logic claim;        // create: take current slot
        logic create_fail;  // create: pool full
        logic op_exec;      // start / stop / destroy / unknown
        logic push_reply;   // send the reply
    } ptp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic idx_last;
        logic slot_free;
        logic expired;
        logic pend_valid;
        logic out_free;
    } ptp_stat_t;

endpackage

[src/ptp_ctrl.sv]
// Sequencer of the periodic timer pool: walks slots and issues datapath commands.
module ptp_ctrl
    import ptp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [OP_W-1:0] op,
    output logic            in_ready,
    output ptp_cmd_t        cmd,
    input  ptp_stat_t       stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK_RD,
        S_TICK_EX,
        S_TICK_FLUSH,
        S_CREATE,
        S_OP_RD,
        S_OP_EX,
        S_REPLY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   tick_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // hold the walk when a new expiry would overwrite an unsent report
    assign tick_go = !(stat.expired && stat.pend_valid && !stat.out_free);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (op == OP_TICK)
                    begin
                        state_next = S_TICK_RD;
                    end
                    else if (op == OP_CREATE)
                    begin
                        state_next = S_CREATE;
                    end
                    else
                    begin
                        state_next = S_OP_RD;
                    end
                end
            end
            S_TICK_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_TICK_EX;
            end
            S_TICK_EX:
            begin
                if (tick_go)
                begin
                    cmd.tick_step = 1'b1;
                    if (stat.idx_last)
                    begin
                        state_next = S_TICK_FLUSH;
                    end
                    else
                    begin
                        cmd.idx_inc  = 1'b1;
                        cmd.rd_ahead = 1'b1;
                    end
                end
            end
            S_TICK_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CREATE:
            begin
                if (stat.slot_free)
                begin
                    cmd.claim  = 1'b1;
                    state_next = S_REPLY;
                end
                else if (stat.idx_last)
                begin
                    cmd.create_fail = 1'b1;
                    state_next      = S_REPLY;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_OP_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_OP_EX;
            end
            S_OP_EX:
            begin
                cmd.op_exec = 1'b1;
                state_next  = S_REPLY;
            end
            S_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.push_reply = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[src/ptp_datapath.sv]
// Slot storage, per-slot arithmetic and result register of the periodic timer pool.
module ptp_datapath
    import ptp_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [OP_W-1:0]     op,
    input  logic [SLOT_W-1:0]   timer_index,
    input  logic [TIME_W-1:0]   timeout_ms,
    input  ptp_cmd_t            cmd,
    output ptp_stat_t           stat,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                kind,
    output logic [SLOT_W-1:0]   slot,
    output logic [STATUS_W-1:0] status,
    output logic                last
);

    localparam int POOL  = (NUM_TIMERS < MAX_POOL) ? NUM_TIMERS : MAX_POOL;
    localparam int IDX_W = (POOL > 1) ? $clog2(POOL) : 1;
    localparam logic [SLOT_W:0] POOL_V = (SLOT_W + 1)'(POOL);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POOL - 1);

    timer_word_t               mem [POOL];
    timer_word_t               rdata_reg;
    logic [MODE_W-1:0]         mode_reg [POOL];

    logic [OP_W-1:0]           op_reg;
    logic [SLOT_W-1:0]         tidx_reg;
    logic [TIME_W-1:0]         timeout_reg;
    logic [IDX_W-1:0]          idx_reg;

    logic                      pend_valid_reg;
    logic [SLOT_W-1:0]         pend_slot_reg;
    logic [SLOT_W-1:0]         reply_slot_reg;
    logic [STATUS_W-1:0]       reply_status_reg;

    logic                      out_valid_reg;
    logic                      kind_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic                      last_reg;

    logic [MODE_W-1:0]         cur_mode;
    logic                      running;
    logic                      active;
    logic                      in_range;
    logic [IDX_W-1:0]          rd_addr;
    logic [TIME_W-1:0]         since_inc;
    logic                      expired;
    timer_word_t               tick_word;
    timer_word_t               op_word;
    timer_word_t               wdata;
    logic                      we;
    logic                      op_ok;
    logic                      op_wr;
    logic [MODE_W-1:0]         op_mode;
    logic                      push_mid;
    logic                      push_last;
    logic                      out_free;

    assign cur_mode = mode_reg[idx_reg];
    assign running  = (cur_mode == MODE_RUNNING);
    assign active   = running || (cur_mode == MODE_STOPPED);
    assign in_range = ({1'b0, tidx_reg} < POOL_V);
    assign rd_addr  = cmd.rd_ahead ? IDX_W'(idx_reg + IDX_W'(1)) : idx_reg;

    // tick: saturating count, expiry when it passes the remaining time
    assign since_inc = (rdata_reg.since_start == '1) ? rdata_reg.since_start
                                                      : rdata_reg.since_start + TIME_W'(1);
    assign expired   = running && (since_inc > rdata_reg.remaining);

    always_comb
    begin
        tick_word = rdata_reg;
        if (expired)
        begin
            tick_word.remaining   = rdata_reg.period;
            tick_word.since_start = '0;
        end
        else
        begin
            tick_word.since_start = since_inc;
        end
    end

    // start / stop / destroy
    always_comb
    begin
        op_word = rdata_reg;
        op_ok   = 1'b0;
        op_wr   = 1'b0;
        op_mode = cur_mode;
        priority if (op_reg == OP_START)
        begin
            op_ok = in_range && active;
            op_wr = op_ok;
            if (timeout_reg != '0)
            begin
                op_word.period    = timeout_reg;
                op_word.remaining = timeout_reg;
            end
            op_word.since_start = '0;
            op_mode = MODE_RUNNING;
        end
        else if (op_reg == OP_STOP)
        begin
            op_ok = in_range && running;
            op_wr = op_ok;
            if (rdata_reg.remaining > rdata_reg.since_start)
            begin
                op_word.remaining = rdata_reg.remaining - rdata_reg.since_start;
            end
            else
            begin
                op_word.remaining = '0;
            end
            op_mode = MODE_STOPPED;
        end
        else if (op_reg == OP_DESTROY)
        begin
            op_ok   = in_range && active;
            op_mode = MODE_FREE;
        end
        else
        begin
            op_ok = 1'b0;
        end
    end

    always_comb
    begin
        wdata = '0;
        we    = 1'b0;
        if (cmd.tick_step)
        begin
            wdata = tick_word;
            we    = running;
        end
        else if (cmd.claim)
        begin
            wdata = '0;
            we    = 1'b1;
        end
        else if (cmd.op_exec)
        begin
            wdata = op_word;
            we    = op_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[idx_reg] <= wdata;
        end
        if (cmd.rd || cmd.rd_ahead)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POOL; i++)
            begin
                mode_reg[i] <= MODE_FREE;
            end
        end
        else if (cmd.claim)
        begin
            mode_reg[idx_reg] <= MODE_STOPPED;
        end
        else if (cmd.op_exec && op_ok)
        begin
            mode_reg[idx_reg] <= op_mode;
        end
    end

    // request fields and slot pointer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op;
            tidx_reg    <= timer_index;
            timeout_reg <= timeout_ms;
            idx_reg     <= (op == OP_TICK || op == OP_CREATE) ? '0
                                                              : timer_index[IDX_W-1:0];
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= IDX_W'(idx_reg + IDX_W'(1));
        end
        if (cmd.claim)
        begin
            reply_slot_reg   <= SLOT_W'(idx_reg);
            reply_status_reg <= ST_OK;
        end
        else if (cmd.create_fail)
        begin
            reply_slot_reg   <= '0;
            reply_status_reg <= ST_NO_SLOT;
        end
        else if (cmd.op_exec)
        begin
            reply_slot_reg   <= tidx_reg;
            reply_status_reg <= op_ok ? ST_OK : ST_BAD_STATE;
        end
    end

    // one expiry is held back until the next one or the end of the walk
    assign push_mid  = cmd.tick_step && expired && pend_valid_reg;
    assign push_last = cmd.flush && pend_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.tick_step && expired)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (cmd.flush)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_step && expired)
        begin
            pend_slot_reg <= SLOT_W'(idx_reg);
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push_reply || push_mid || push_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_reply)
        begin
            kind_reg   <= KIND_REPLY;
            slot_reg   <= reply_slot_reg;
            status_reg <= reply_status_reg;
            last_reg   <= 1'b1;
        end
        else if (push_mid || push_last)
        begin
            kind_reg   <= KIND_EXPIRY;
            slot_reg   <= pend_slot_reg;
            status_reg <= ST_OK;
            last_reg   <= push_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign slot      = slot_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    assign stat.idx_last   = (idx_reg == IDX_LAST);
    assign stat.slot_free  = !active;
    assign stat.expired    = expired;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

endmodule

[src/periodic_timer_pool.sv]
// Top level of the periodic timer pool: controller plus datapath.
//
// A pool of up to 32 periodic millisecond timers (min(NUM_TIMERS, 32) slots).
// Each request is one operation: tick, create, start, stop or destroy. Every
// operation except tick returns exactly one reply (kind 0, last 1). A tick
// returns one expiry report (kind 1) per timer that ran out, in slot order,
// with last set on the final one, and nothing at all when none expired.
// One request is handled at a time. The slot words (period, remaining time,
// count since start) live in a memory with one read and one write port and
// registered read, so a tick walks the slots one per cycle when the output
// is not stalled. Create scans the slot modes one per cycle; start, stop and
// destroy read the slot word, execute and then reply. Results leave through an
// output register, so a stalled consumer only holds the walk when a second
// expiry report is ready before the first has gone. Slot memory needs no
// clearing pass after reset: a slot's word is zeroed when it is created and
// its contents are never used before that.
module periodic_timer_pool
    import ptp_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     op,
    input  logic [SLOT_W-1:0]   timer_index,
    input  logic [TIME_W-1:0]   timeout_ms,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                kind,
    output logic [SLOT_W-1:0]   slot,
    output logic [STATUS_W-1:0] status,
    output logic                last
);

    ptp_cmd_t  cmd;
    ptp_stat_t stat;

    // sequencer: one request at a time
    ptp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // slot memory, mode flops, arithmetic and output register
    ptp_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .timer_index (timer_index),
        .timeout_ms  (timeout_ms),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .slot        (slot),
        .status      (status),
        .last        (last)
    );

endmodule

[src/ptp_checker.sv]
// Port-level assertions of the periodic timer pool and their bind.
module ptp_checker
    import ptp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [OP_W-1:0]     op,
    input logic                out_valid,
    input logic                out_ready,
    input logic                kind,
    input logic [SLOT_W-1:0]   slot,
    input logic [STATUS_W-1:0] status,
    input logic                last
);

    // replies are always the only result of their request
    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_REPLY |-> last)
        else $error("reply without last");

    // expiry reports carry ok status
    a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_EXPIRY |-> status == ST_OK)
        else $error("expiry report with error status");

    // pool-full reply names slot zero
    a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_NO_SLOT |-> kind == KIND_REPLY && slot == '0)
        else $error("bad pool-full reply");

    // a non-tick request blocks the input on the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op != OP_TICK |=> !in_ready)
        else $error("request taken while busy");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(kind)
                                    && $stable(last))
        else $error("stalled result changed");

endmodule

bind periodic_timer_pool ptp_checker u_ptp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .slot      (slot),
    .status    (status),
    .last      (last)
);
